// ===== rtl/drpl_pkg.sv =====
// package: shared types, codes and reset values for the dual relay pulse lockout block
package drpl_pkg;

  // register reset values and field widths
  localparam int unsigned CFG_WIDTH           = 16;
  localparam int unsigned DUR_WIDTH           = 16;
  localparam int unsigned IDX_WIDTH           = 2;
  localparam int unsigned EVT_WIDTH           = 2;
  localparam int unsigned RELAY_COUNT_DEFAULT = 2;
  localparam int unsigned TIMER_WIDTH_DEFAULT = 16;

  localparam logic [CFG_WIDTH-1:0] LOCKOUT_RESET   = 16'd5000;
  localparam logic [CFG_WIDTH-1:0] MIN_PULSE_RESET = 16'd100;
  localparam logic [CFG_WIDTH-1:0] MAX_PULSE_RESET = 16'd10000;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PULSE  = 2'd1,
    OP_TOGGLE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BLOCKED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_LOCKOUT   = 2'd0,
    CFG_MIN_PULSE = 2'd1,
    CFG_MAX_PULSE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    op_t                   opcode;
    logic [IDX_WIDTH-1:0]  relay_index;
    logic [DUR_WIDTH-1:0]  pulse_len;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic                  door_on;
    logic                  light_on;
    logic [EVT_WIDTH-1:0]  event_mask;
    logic                  queried_state;
  } out_item_t;

endpackage

// ===== rtl/drpl_stream_if.sv =====
// interface: valid/ready channel carrying one payload item per transfer
interface drpl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dual_relay_pulse_lockout.sv =====
// top level: two-relay pulse controller with duration bounds and per-relay lockout
//
//  channel  | dir | payload                                         | transfer when
//  ---------+-----+-------------------------------------------------+----------------------
//  in_ch    | in  | opcode, relay_index, pulse_len                  | in_ch.valid & ready
//  out_ch   | out | status, door_on, light_on, event_mask, queried  | out_ch.valid & ready
//  cfg_*    | in  | cfg_index, cfg_wdata                            | cfg_we high
//
// one item per cycle sustained while out_ch.ready stays high; an item goes into the
// input register, is worked in one pass against the relay state and lands in the
// result register, from which it is offered on out_ch
// synchronous active-low reset: relays off, countdowns idle, lockout counters at
// zero, registers back to their defaults, both stages empty
// a stalled result holds the result register; the input register still takes one
// more item, then in_ch.ready drops until out_ch.ready returns
module dual_relay_pulse_lockout #(
  parameter int unsigned RELAY_COUNT = drpl_pkg::RELAY_COUNT_DEFAULT,
  parameter int unsigned TIMER_WIDTH = drpl_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  drpl_stream_if.sink                   in_ch,
  drpl_stream_if.source                 out_ch,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [drpl_pkg::CFG_WIDTH-1:0] cfg_wdata
);

  // compare width covers both the 16-bit fields and the timer width
  localparam int unsigned CW = (TIMER_WIDTH > drpl_pkg::CFG_WIDTH) ?
                               TIMER_WIDTH : drpl_pkg::CFG_WIDTH;
  // padded relay view so every 2-bit index and both event bits are addressable
  localparam int unsigned LW = (RELAY_COUNT < 4) ? 4 : RELAY_COUNT;
  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

  // configuration registers
  logic [drpl_pkg::CFG_WIDTH-1:0] lockout_r, min_pulse_r, max_pulse_r;

  // input register and result register
  logic                stg_v_r;
  drpl_pkg::in_item_t  stg_r;
  logic                out_v_r;
  drpl_pkg::out_item_t out_r, out_nxt;

  // per-relay state
  logic                   lvl_r [RELAY_COUNT];
  logic                   act_r [RELAY_COUNT];
  logic [TIMER_WIDTH-1:0] rem_r [RELAY_COUNT];
  logic [TIMER_WIDTH-1:0] slp_r [RELAY_COUNT];
  logic                   lvl_nxt [RELAY_COUNT];
  logic                   act_nxt [RELAY_COUNT];
  logic [TIMER_WIDTH-1:0] rem_nxt [RELAY_COUNT];
  logic [TIMER_WIDTH-1:0] slp_nxt [RELAY_COUNT];

  logic                   proc;
  logic                   idx_valid;
  logic                   dur_ok, lock_ok;
  logic                   pulse_go, toggle_go;
  logic [TIMER_WIDTH-1:0] slp_sel;
  logic [TIMER_WIDTH-1:0] dur_load;
  logic [CW-1:0]          dur_cw;
  logic [LW-1:0]          lvl_pad;
  logic [LW-1:0]          evt_pad;
  drpl_pkg::status_t      status;

  // work the staged item when the result slot is free or being emptied
  assign proc        = stg_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !stg_v_r || proc;

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r   <= drpl_pkg::LOCKOUT_RESET;
      min_pulse_r <= drpl_pkg::MIN_PULSE_RESET;
      max_pulse_r <= drpl_pkg::MAX_PULSE_RESET;
    end else if (cfg_we) begin
      case (drpl_pkg::cfg_idx_t'(cfg_index))
        drpl_pkg::CFG_LOCKOUT:   lockout_r   <= cfg_wdata;
        drpl_pkg::CFG_MIN_PULSE: min_pulse_r <= cfg_wdata;
        drpl_pkg::CFG_MAX_PULSE: max_pulse_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // selected relay's lockout counter
  always_comb begin
    slp_sel = '0;
    for (int r = 0; r < RELAY_COUNT; r++) begin
      if (32'(stg_r.relay_index) == r) begin
        slp_sel = slp_r[r];
      end
    end
  end

  // command checks: index, then duration bounds, then lockout
  always_comb begin
    idx_valid = 32'(stg_r.relay_index) < RELAY_COUNT;
    dur_ok    = (stg_r.pulse_len >= min_pulse_r) && (stg_r.pulse_len <= max_pulse_r);
    lock_ok   = CW'(slp_sel) >= CW'(lockout_r);
    dur_cw    = CW'(stg_r.pulse_len);
    // countdown load saturates at the timer maximum
    dur_load  = (dur_cw > CW'(TMAX)) ? TMAX : dur_cw[TIMER_WIDTH-1:0];
    pulse_go  = (stg_r.opcode == drpl_pkg::OP_PULSE) && idx_valid && dur_ok && lock_ok;
    toggle_go = (stg_r.opcode == drpl_pkg::OP_TOGGLE) && idx_valid;

    case (stg_r.opcode)
      drpl_pkg::OP_TICK: status = drpl_pkg::ST_OK;
      drpl_pkg::OP_PULSE: begin
        if (!idx_valid || !dur_ok) status = drpl_pkg::ST_INVALID;
        else if (!lock_ok)        status = drpl_pkg::ST_BLOCKED;
        else                      status = drpl_pkg::ST_OK;
      end
      drpl_pkg::OP_TOGGLE,
      drpl_pkg::OP_QUERY: status = idx_valid ? drpl_pkg::ST_OK : drpl_pkg::ST_INVALID;
      default: status = drpl_pkg::ST_OK;
    endcase
  end

  // per-relay next state, each relay independent
  always_comb begin
    lvl_pad = '0;
    evt_pad = '0;
    for (int r = 0; r < RELAY_COUNT; r++) begin
      lvl_nxt[r] = lvl_r[r];
      act_nxt[r] = act_r[r];
      rem_nxt[r] = rem_r[r];
      slp_nxt[r] = slp_r[r];
      if (stg_r.opcode == drpl_pkg::OP_TICK) begin
        // lockout counter saturates
        if (slp_r[r] != TMAX) slp_nxt[r] = slp_r[r] + 1'b1;
        if (act_r[r]) begin
          if (rem_r[r] <= TIMER_WIDTH'(1)) begin
            // expiry turns the relay off and always reports, even if already off
            rem_nxt[r] = '0;
            act_nxt[r] = 1'b0;
            lvl_nxt[r] = 1'b0;
            evt_pad[r] = 1'b1;
          end else begin
            rem_nxt[r] = rem_r[r] - 1'b1;
          end
        end
      end else if (32'(stg_r.relay_index) == r) begin
        if (pulse_go) begin
          lvl_nxt[r] = 1'b1;
          act_nxt[r] = 1'b1;
          rem_nxt[r] = dur_load;
          slp_nxt[r] = '0;
          evt_pad[r] = 1'b1;
        end else if (toggle_go) begin
          // toggle leaves any running countdown alone
          lvl_nxt[r] = !lvl_r[r];
          evt_pad[r] = 1'b1;
        end
      end
      lvl_pad[r] = lvl_nxt[r];
    end
  end

  // result assembly
  always_comb begin
    out_nxt.status        = status;
    out_nxt.door_on       = lvl_pad[0];
    out_nxt.light_on      = lvl_pad[1];
    out_nxt.event_mask    = evt_pad[drpl_pkg::EVT_WIDTH-1:0];
    out_nxt.queried_state = idx_valid && lvl_pad[stg_r.relay_index];
  end

  // relay state commits only when the staged item is worked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < RELAY_COUNT; r++) begin
        lvl_r[r] <= 1'b0;
        act_r[r] <= 1'b0;
        rem_r[r] <= '0;
        slp_r[r] <= '0;
      end
    end else if (proc) begin
      for (int r = 0; r < RELAY_COUNT; r++) begin
        lvl_r[r] <= lvl_nxt[r];
        act_r[r] <= act_nxt[r];
        rem_r[r] <= rem_nxt[r];
        slp_r[r] <= slp_nxt[r];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_r <= in_ch.data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_r <= out_nxt;
    end
  end

endmodule
